@@ rtl/sef_pkg.sv @@
// shared types, constants and helpers of the 3x3 sobel edge filter
`default_nettype none

package sef_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int SIZE_RESET     = 1024;
  localparam int CFG_DATA_W     = 11;
  localparam int PIX_W          = 8;
  localparam int POS_W          = 10;
  localparam int LS_W           = 2 * PIX_W;
  localparam int GRP_DEPTH      = 8;
  localparam int NUM_SLOTS      = 4;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // result positions around the pixel just taken, in raster order
  typedef enum logic [1:0] {
    SLOT_UL = 2'd0,
    SLOT_UR = 2'd1,
    SLOT_LL = 2'd2,
    SLOT_LR = 2'd3
  } slot_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
  } pix_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] out_value;
    logic             run_last;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    reg_idx_e              index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  // position and neighborhood flags of one pixel
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             prev_row;
    logic             last_row;
    logic             prev_col;
    logic             last_col;
    logic             interior;
  } pos_tag_t;

  // all results caused by one pixel
  typedef struct packed {
    logic [POS_W-1:0]                row;
    logic [POS_W-1:0]                col;
    logic [NUM_SLOTS-1:0]            mask;
    logic                            frame_end;
    logic [NUM_SLOTS-1:0][PIX_W-1:0] vals;
  } grp_t;

  function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
    int unsigned r;
    r = 32'(v);
    if (v == '0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sef_stream_if.sv @@
// valid/ready channel carrying one payload beat
`default_nettype none

interface sef_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sef_line_store.sv @@
// line store ram: two previous rows per column, one read and one write port
`default_nettype none

module sef_line_store #(
  parameter int DEPTH = sef_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                       clk_i,
  input  wire                       rd_en_i,
  input  wire  [AW-1:0]             rd_addr_i,
  output logic [sef_pkg::LS_W-1:0]  rd_data_o,
  input  wire                       wr_en_i,
  input  wire  [AW-1:0]             wr_addr_i,
  input  wire  [sef_pkg::LS_W-1:0]  wr_data_i
);
  import sef_pkg::*;

  logic [LS_W-1:0] mem_q [DEPTH];
  logic [LS_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/sef_window.sv @@
// line store access, 3x3 window and sobel datapath producing one result group per pixel
`default_nettype none

module sef_window #(
  parameter int MAX_WIDTH = sef_pkg::DEF_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        accept_i,
  input  wire  [AW-1:0]              addr_i,
  input  wire  [sef_pkg::PIX_W-1:0]  pixel_i,
  input  wire  sef_pkg::pos_tag_t    tag_i,
  output logic                       grp_valid_o,
  output sef_pkg::grp_t              grp_o
);
  import sef_pkg::*;

  // stage 1: ram data arrives, window shifts, ram written back
  logic             s1_valid_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  pos_tag_t         s1_tag_q;
  logic [LS_W-1:0]  ram_rd;
  logic [LS_W-1:0]  rd_data;
  logic [LS_W-1:0]  wr_data;
  logic             fwd_q;
  logic [LS_W-1:0]  fwd_data_q;
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] above2;

  // window row-major: [row][col], col 2 newest
  logic [2:0][2:0][PIX_W-1:0] win_q;
  logic [2:0][2:0][PIX_W-1:0] win_d;
  logic                       w_valid_q;
  pos_tag_t                   w_tag_q;

  // stage 2: gradients
  logic [PIX_W+1:0]         left, right, top, bottom;
  logic signed [PIX_W+2:0]  gx_d, gy_d;
  logic signed [PIX_W+2:0]  gx_q, gy_q;
  logic                     g_valid_q;
  pos_tag_t                 g_tag_q;
  logic [NUM_SLOTS-1:0][PIX_W-1:0] border_q;

  // stage 3: sum, halve, clamp
  logic signed [PIX_W+3:0] sum;
  logic signed [PIX_W+3:0] adj;
  logic signed [PIX_W+3:0] half;
  logic [PIX_W-1:0]        sobel;
  grp_t                    grp_d;
  grp_t                    grp_q;
  logic                    grp_valid_q;

  sef_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept_i),
    .rd_addr_i (addr_i),
    .rd_data_o (ram_rd),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      // read of the entry being written this cycle sees the old word
      fwd_q      <= accept_i && s1_valid_q && (addr_i == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_addr_q <= addr_i;
      s1_pix_q  <= pixel_i;
      s1_tag_q  <= tag_i;
    end
    fwd_data_q <= wr_data;
  end

  assign rd_data = fwd_q ? fwd_data_q : ram_rd;
  assign above   = rd_data[LS_W-1:PIX_W];
  assign above2  = rd_data[PIX_W-1:0];
  assign wr_data = {s1_pix_q, above};

  always_comb begin
    win_d = win_q;
    if (s1_valid_q) begin
      for (int a = 0; a < 3; a++) begin
        win_d[a][0] = win_q[a][1];
        win_d[a][1] = win_q[a][2];
      end
      win_d[0][2] = above2;
      win_d[1][2] = above;
      win_d[2][2] = s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      w_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      grp_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      w_valid_q   <= s1_valid_q;
      g_valid_q   <= w_valid_q;
      grp_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      w_tag_q <= s1_tag_q;
    end
  end

  always_comb begin
    left   = {2'b00, win_q[0][0]} + {1'b0, win_q[1][0], 1'b0} + {2'b00, win_q[2][0]};
    right  = {2'b00, win_q[0][2]} + {1'b0, win_q[1][2], 1'b0} + {2'b00, win_q[2][2]};
    top    = {2'b00, win_q[0][0]} + {1'b0, win_q[0][1], 1'b0} + {2'b00, win_q[0][2]};
    bottom = {2'b00, win_q[2][0]} + {1'b0, win_q[2][1], 1'b0} + {2'b00, win_q[2][2]};
    gx_d   = $signed({1'b0, left}) - $signed({1'b0, right});
    gy_d   = $signed({1'b0, top}) - $signed({1'b0, bottom});
  end

  always_ff @(posedge clk_i) begin
    if (w_valid_q) begin
      gx_q              <= gx_d;
      gy_q              <= gy_d;
      g_tag_q           <= w_tag_q;
      border_q[SLOT_UL] <= win_q[1][1];
      border_q[SLOT_UR] <= win_q[1][2];
      border_q[SLOT_LL] <= win_q[2][1];
      border_q[SLOT_LR] <= win_q[2][2];
    end
  end

  always_comb begin
    sum  = {gx_q[PIX_W+2], gx_q} + {gy_q[PIX_W+2], gy_q};
    // halve toward zero
    adj  = sum + {{(PIX_W+3){1'b0}}, sum[PIX_W+3]};
    half = adj >>> 1;
    if (half[PIX_W+3]) begin
      sobel = '0;
    end else if (half > $signed({{4{1'b0}}, {PIX_W{1'b1}}})) begin
      sobel = '1;
    end else begin
      sobel = half[PIX_W-1:0];
    end

    grp_d.row             = g_tag_q.row;
    grp_d.col             = g_tag_q.col;
    grp_d.mask[SLOT_UL]   = g_tag_q.prev_row && g_tag_q.prev_col;
    grp_d.mask[SLOT_UR]   = g_tag_q.prev_row && g_tag_q.last_col;
    grp_d.mask[SLOT_LL]   = g_tag_q.last_row && g_tag_q.prev_col;
    grp_d.mask[SLOT_LR]   = g_tag_q.last_row && g_tag_q.last_col;
    grp_d.frame_end       = g_tag_q.last_row && g_tag_q.last_col;
    grp_d.vals            = border_q;
    // only the pixel diagonally up-left can be an interior one
    if (g_tag_q.interior) begin
      grp_d.vals[SLOT_UL] = sobel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_valid_q) begin
      grp_q <= grp_d;
    end
  end

  assign grp_valid_o = grp_valid_q;
  assign grp_o       = grp_q;

endmodule

`default_nettype wire

@@ rtl/sef_expand.sv @@
// group queue and expansion of each group into result beats
`default_nettype none

module sef_expand (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  wire sef_pkg::grp_t grp_i,
  output logic           retire_o,
  sef_stream_if.source   res_if
);
  import sef_pkg::*;

  localparam int PW = $clog2(GRP_DEPTH);

  grp_t                 fifo_q [GRP_DEPTH];
  logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [PW:0]          cnt_q;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  res_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;

  grp_t                 head;
  logic                 nonempty;
  logic [NUM_SLOTS-1:0] rem;
  logic [NUM_SLOTS-1:0] after;
  logic                 found;
  slot_e                sel;
  logic                 load;
  logic                 emit;
  logic                 pop;

  assign head     = fifo_q[rd_ptr_q];
  assign nonempty = (cnt_q != '0);

  always_comb begin
    rem   = head.mask & ~used_q;
    found = 1'b0;
    sel   = SLOT_UL;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (rem[i] && !found) begin
        found = 1'b1;
        sel   = slot_e'(i[1:0]);
      end
    end
    after = found ? (rem & ~(NUM_SLOTS'(1) << sel)) : '0;
    load  = !out_valid_q || res_if.ready;
    emit  = nonempty && found && load;
    pop   = nonempty && (!found || load) && (after == '0);

    used_d = used_q;
    if (pop) begin
      used_d = '0;
    end else if (emit) begin
      used_d = used_q | (NUM_SLOTS'(1) << sel);
    end

    res_d           = res_q;
    res_d.out_value = head.vals[sel];
    res_d.run_last  = (after == '0);
    res_d.frame_end = head.frame_end && (sel == SLOT_LR);
    case (sel)
      SLOT_UL: begin
        res_d.out_row = head.row - POS_W'(1);
        res_d.out_col = head.col - POS_W'(1);
      end
      SLOT_UR: begin
        res_d.out_row = head.row - POS_W'(1);
        res_d.out_col = head.col;
      end
      SLOT_LL: begin
        res_d.out_row = head.row;
        res_d.out_col = head.col - POS_W'(1);
      end
      SLOT_LR: begin
        res_d.out_row = head.row;
        res_d.out_col = head.col;
      end
      default: begin
        res_d.out_row = head.row;
        res_d.out_col = head.col;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q       <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop);
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= grp_i;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign retire_o     = pop;
  assign res_if.valid = out_valid_q;
  assign res_if.data  = res_q;

endmodule

`default_nettype wire

@@ rtl/sobel_edge_filter_3x3.sv @@
// path of a beat: ram read, window, gradient and group registers, group queue, output register
// throughput: one pixel per cycle while credit lasts; one result beat per cycle while res_if is
// ready, via a single output register; last row/column pixels (up to 4 results) may stall input
// an 8-entry group queue with a credit count sets how far input may run ahead of the output
// reset: position counters zero, width and height at 1024 (clipped to the maximum), window zero
// the line store ram is not cleared; entries are always written before any result uses them
`default_nettype none

module sobel_edge_filter_3x3 #(
  parameter int MAX_WIDTH  = sef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sef_pkg::DEF_MAX_HEIGHT
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  sef_stream_if.sink   pix_if,
  sef_stream_if.source res_if,
  sef_stream_if.sink   cfg_if
);
  import sef_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int FW = $clog2(GRP_DEPTH + 1);

  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [FW-1:0] in_flight_q;

  logic          pix_fire;
  logic          cfg_fire;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          last_col;
  logic          last_row;
  pos_tag_t      tag;
  logic          grp_valid;
  grp_t          grp;
  logic          retire;

  assign pix_if.ready = (in_flight_q < FW'(GRP_DEPTH));
  assign cfg_if.ready = 1'b1;
  assign pix_fire     = pix_if.valid && pix_if.ready;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;

  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = HW'(row_q) + HW'(1);
  assign last_col = (col_inc >= width_q);
  assign last_row = (row_inc >= height_q);

  always_comb begin
    tag.row      = POS_W'(row_q);
    tag.col      = POS_W'(col_q);
    tag.prev_row = (row_q != '0);
    tag.last_row = last_row;
    tag.prev_col = (col_q != '0);
    tag.last_col = last_col;
    tag.interior = (row_q > RW'(1)) && (col_q > CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(clamp_size(CFG_DATA_W'(SIZE_RESET), MAX_WIDTH));
      height_q <= HW'(clamp_size(CFG_DATA_W'(SIZE_RESET), MAX_HEIGHT));
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_fire) begin
      // any register write restarts the frame
      case (cfg_if.data.index)
        REG_WIDTH: begin
          width_q <= WW'(clamp_size(cfg_if.data.wdata, MAX_WIDTH));
        end
        REG_HEIGHT: begin
          height_q <= HW'(clamp_size(cfg_if.data.wdata, MAX_HEIGHT));
        end
        default: begin
          width_q <= width_q;
        end
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (pix_fire) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= '0;
    end else begin
      in_flight_q <= in_flight_q + FW'(pix_fire) - FW'(retire);
    end
  end

  sef_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (CW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (pix_fire),
    .addr_i      (col_q),
    .pixel_i     (pix_if.data.pixel_in),
    .tag_i       (tag),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  sef_expand u_expand (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (grp_valid),
    .grp_i    (grp),
    .retire_o (retire),
    .res_if   (res_if)
  );

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q <= FW'(GRP_DEPTH))
    else $error("group credit count overran the queue depth");

  a_retire_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire |-> (in_flight_q != '0) || pix_fire)
    else $error("group retired with none in flight");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < width_q)
    else $error("column counter outside configured width");

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && res_if.data.frame_end |-> res_if.data.run_last)
    else $error("frame end beat is not the last of its pixel");
`endif

endmodule

`default_nettype wire

@@ tb/tb_sobel_edge_filter_3x3.sv @@
// testbench of the 3x3 sobel edge filter: pixel streams, random stalls and a predicting scoreboard
`timescale 1ns / 1ps

module tb_sobel_edge_filter_3x3;
  import sef_pkg::*;

  class sobel_scoreboard;
    bit [PIX_W-1:0]        line_mem [2*DEF_MAX_WIDTH];
    bit [PIX_W-1:0]        win_px [9];
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    res_t                  due_pixels [$];
    int unsigned           mismatches;
    int unsigned           pixels_in;
    int unsigned           results_ok;
    int unsigned           reg_writes;

    function void clear();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win_px[i]) win_px[i] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = CFG_DATA_W'(SIZE_RESET);
      height_reg = CFG_DATA_W'(SIZE_RESET);
      due_pixels.delete();
      mismatches = 0;
      pixels_in  = 0;
      results_ok = 0;
      reg_writes = 0;
    endfunction

    // zero acts as one, anything past the maximum as the maximum
    function int unsigned eff_size(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
    endfunction

    function int unsigned frame_pixels();
      return eff_size(width_reg, DEF_MAX_WIDTH) * eff_size(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function bit [PIX_W-1:0] sobel_mag();
      int lft, rgt, top, bot, v;
      lft = int'(win_px[0]) + 2 * int'(win_px[3]) + int'(win_px[6]);
      rgt = int'(win_px[2]) + 2 * int'(win_px[5]) + int'(win_px[8]);
      top = int'(win_px[0]) + 2 * int'(win_px[1]) + int'(win_px[2]);
      bot = int'(win_px[6]) + 2 * int'(win_px[7]) + int'(win_px[8]);
      v = ((lft - rgt) + (top - bot)) / 2;
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[PIX_W-1:0];
    endfunction

    function void write_reg(cfg_t cw);
      if (cw.index == REG_WIDTH) begin
        width_reg = cw.wdata;
      end else begin
        height_reg = cw.wdata;
      end
      row_pos = 0;
      col_pos = 0;
      reg_writes++;
    endfunction

    function void take_pixel(pix_t p);
      int unsigned w, h, r, c, rr, cc;
      int unsigned rows [2];
      int unsigned cols [2];
      bit [PIX_W-1:0] above, above2;
      int nr, nc;
      bit interior;
      res_t res;
      w = eff_size(width_reg, DEF_MAX_WIDTH);
      h = eff_size(height_reg, DEF_MAX_HEIGHT);
      r = row_pos;
      c = col_pos;
      above  = line_mem[c];
      above2 = line_mem[DEF_MAX_WIDTH + c];
      for (int a = 0; a < 3; a++) begin
        win_px[a*3]   = win_px[a*3+1];
        win_px[a*3+1] = win_px[a*3+2];
      end
      win_px[2] = above2;
      win_px[5] = above;
      win_px[8] = p.pixel_in;
      line_mem[DEF_MAX_WIDTH + c] = above;
      line_mem[c] = p.pixel_in;
      nr = 0;
      nc = 0;
      if (r >= 1) begin
        rows[nr] = r - 1;
        nr++;
      end
      if (r + 1 == h) begin
        rows[nr] = r;
        nr++;
      end
      if (c >= 1) begin
        cols[nc] = c - 1;
        nc++;
      end
      if (c + 1 == w) begin
        cols[nc] = c;
        nc++;
      end
      for (int a = 0; a < nr; a++) begin
        for (int b = 0; b < nc; b++) begin
          rr = rows[a];
          cc = cols[b];
          interior = (rr >= 1) && (rr + 2 <= h) && (cc >= 1) && (cc + 2 <= w);
          res.out_row = rr[POS_W-1:0];
          res.out_col = cc[POS_W-1:0];
          // border pixels pass through from their place in the window
          if (interior) begin
            res.out_value = sobel_mag();
          end else begin
            res.out_value = win_px[(2 - (r - rr)) * 3 + (2 - (c - cc))];
          end
          res.run_last  = (a == nr - 1) && (b == nc - 1);
          res.frame_end = (rr + 1 == h) && (cc + 1 == w);
          due_pixels.push_back(res);
        end
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
      pixels_in++;
    endfunction

    function void cmp_field(string name, int unsigned want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_pixels.size() == 0) begin
        $error("result beat with nothing due: row %0d col %0d", got.out_row, got.out_col);
        mismatches++;
        return;
      end
      want = due_pixels.pop_front();
      cmp_field("out_row", 32'(want.out_row), 32'(got.out_row));
      cmp_field("out_col", 32'(want.out_col), 32'(got.out_col));
      cmp_field("out_value", 32'(want.out_value), 32'(got.out_value));
      cmp_field("run_last", 32'(want.run_last), 32'(got.run_last));
      cmp_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
      results_ok++;
    endfunction
  endclass

  // pixels spent on randomly sized images
  localparam int unsigned RAND_PX = 270;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_en;

  sobel_scoreboard book;

  sef_stream_if #(.T(pix_t)) pix_if ();
  sef_stream_if #(.T(res_t)) res_if ();
  sef_stream_if #(.T(cfg_t)) cfg_if ();

  logic [PIX_W-1:0] sat_hi [9] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
                                   8'd255, 8'd0, 8'd0};
  logic [PIX_W-1:0] sat_lo [9] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
                                   8'd0, 8'd255, 8'd255};
  logic [PIX_W-1:0] cut_off [4] = '{8'd17, 8'd200, 8'd3, 8'd128};
  logic [PIX_W-1:0] tiny [3] = '{8'd255, 8'd0, 8'd1};

  sobel_edge_filter_3x3 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_if (pix_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) book.check_result(res_if.data);
      if (pix_if.valid && pix_if.ready) book.take_pixel(pix_if.data);
      if (cfg_if.valid && cfg_if.ready) book.write_reg(cfg_if.data);
    end
  end

  // result side: random stall bursts while idling is on
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    if ($urandom_range(0, 4) == 0) return CFG_DATA_W'($urandom_range(0, 2));
    return CFG_DATA_W'($urandom_range(3, 9));
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] v);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.data.pixel_in = v;
    do @(posedge clk_i); while (!pix_if.ready);
    @(negedge clk_i);
  endtask

  task automatic push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pixel(rand_pixel());
  endtask

  // hold input until every due result beat is out, then allow for the pipeline
  task automatic settle();
    pix_if.valid = 1'b0;
    while (book.due_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.data.index = idx;
    cfg_if.data.wdata = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  task automatic configure(input bit wr_w, input logic [CFG_DATA_W-1:0] w,
                           input bit wr_h, input logic [CFG_DATA_W-1:0] h);
    settle();
    if (wr_w) set_reg(REG_WIDTH, w);
    if (wr_h) set_reg(REG_HEIGHT, h);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    int unsigned rand_px, npix, frames, phase_no, sel;
    book = new;
    book.clear();
    idle_en = 1'b0;
    rst_ni = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 3x3 frames: saturation high and low, every border case, four results on the last pixel
    idle_en = 1'b1;
    configure(1'b1, 11'd3, 1'b1, 11'd3);
    foreach (sat_hi[i]) push_pixel(sat_hi[i]);
    foreach (sat_lo[i]) push_pixel(sat_lo[i]);
    // frame cut short by a register write, then zero sizes acting as a 1x1 image
    foreach (cut_off[i]) push_pixel(cut_off[i]);
    configure(1'b1, 11'd0, 1'b1, 11'd0);
    foreach (tiny[i]) push_pixel(tiny[i]);

    // out-of-range width on a single-row image
    configure(1'b1, 11'd2047, 1'b1, 11'd1);
    push_random(24);

    // small random images, some frames abandoned part way
    rand_px = 0;
    phase_no = 0;
    while (rand_px < RAND_PX) begin
      sel = (phase_no == 0) ? 0 : $urandom_range(0, 2);
      configure(sel != 2, pick_size(), sel != 1, pick_size());
      idle_en = $urandom_range(0, 3) != 0;
      frames = $urandom_range(1, 3);
      npix = frames * book.frame_pixels();
      if ($urandom_range(0, 2) == 0) npix += $urandom_range(1, book.frame_pixels());
      if (npix > RAND_PX - rand_px) npix = RAND_PX - rand_px;
      for (int unsigned i = 0; i < npix; i++) begin
        if (i == npix / 2 && (phase_no == 0 || $urandom_range(0, 3) == 0)) settle();
        push_pixel(rand_pixel());
      end
      rand_px += npix;
      phase_no++;
    end

    // closing stretch at full rate on both sides
    idle_en = 1'b0;
    configure(1'b1, 11'd5, 1'b1, 11'd4);
    push_random(2 * book.frame_pixels());
    settle();

    $display("%0d pixels in, %0d result beats checked, %0d register writes",
             book.pixels_in, book.results_ok, book.reg_writes);
    $display("sizes 1x1 to 9x9, zero and oversized sizes, saturation, restarts and stalls");
    if (book.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
